// ----- rtl/lrh_pkg.sv -----
// ----------------------------------------------------------------------------
// lrh_pkg
// Shared constants and types for the LBP region histogram.
// ----------------------------------------------------------------------------
package lrh_pkg;

    localparam int PIX_BITS        = 8;
    localparam int NUM_NEIGHBOURS  = 8;
    localparam int NUM_BINS        = 256;
    localparam int COUNT_BITS      = 11;
    localparam int BINS_PER_RESULT = 4;
    localparam int CODE_BITS       = 8;
    localparam int FIELD_BITS      = 11;

    localparam int NUM_ROWS = NUM_BINS / BINS_PER_RESULT;
    localparam int ROW_BITS = $clog2(NUM_ROWS);
    localparam int SEL_BITS = $clog2(BINS_PER_RESULT);

    localparam int IN_DATA_BITS  = PIX_BITS * (NUM_NEIGHBOURS + 1);
    localparam int OUT_USED_BITS = CODE_BITS + 4 * FIELD_BITS;
    localparam int OUT_DATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [ROW_BITS-1:0]   LAST_ROW  = ROW_BITS'(NUM_ROWS - 1);

    typedef logic [BINS_PER_RESULT-1:0][COUNT_BITS-1:0] t_row;

    typedef enum logic [0:0] {
        ST_ACCUM,
        ST_DRAIN
    } t_state;

endpackage

// ----- rtl/lbp_region_histogram.sv -----
// ----------------------------------------------------------------------------
// lbp_region_histogram
// Local binary pattern histogram over a region, read out in groups of bins.
// ----------------------------------------------------------------------------
// Each input beat carries a centre pixel and eight neighbours. The block
// forms the 8-bit LBP code and increments its bin in a 256-bin saturating
// histogram held in a 64-row memory of four bins per row. Ordinary beats are
// taken at one per cycle; a beat that reads the row written in the cycle
// before gets the new row by forwarding. A beat with tlast set is counted,
// then input is held off while the 64 rows are read out, one result beat per
// row, through the single read port of the memory; a row's read waits until
// the read before it has returned. Rows carry valid bits, so reset clears the
// histogram at once and readout clears it row by row, with no memory sweep.
module lbp_region_histogram
    import lrh_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    // centre_pixel, neighbour_0 .. neighbour_7, from bit 0 up.
    input  logic [IN_DATA_BITS-1:0]  i_s_axis_tdata,
    // region_end.
    input  logic                     i_s_axis_tlast,
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    // first_bin, count_a, count_b, count_c, count_d, zero pad, from bit 0 up.
    output logic [OUT_DATA_BITS-1:0] o_m_axis_tdata,
    // run_last.
    output logic                     o_m_axis_tlast
);

    t_row                  r_mem [NUM_ROWS];
    t_row                  r_mem_rdata;
    logic [NUM_ROWS-1:0]   r_row_vld;

    t_state                r_state;
    t_state                n_state;

    logic                  r_s1_valid;
    logic                  r_s1_last;
    logic [ROW_BITS-1:0]   r_s1_row;
    logic [SEL_BITS-1:0]   r_s1_sel;

    logic                  r_wb_valid;
    logic [ROW_BITS-1:0]   r_wb_row;
    t_row                  r_wb_data;

    logic [ROW_BITS-1:0]   r_rd_row;
    logic                  r_rd_pend;
    logic                  r_rd_vld;
    logic [ROW_BITS-1:0]   r_rd_base;

    logic                  r_out_valid;
    t_row                  r_out_counts;
    logic [ROW_BITS-1:0]   r_out_row;
    logic                  r_out_last;

    logic [CODE_BITS-1:0]  code;
    logic                  in_take;
    logic                  rd_issue;
    logic [ROW_BITS-1:0]   rd_addr;
    t_row                  old_row;
    t_row                  new_row;

    always_comb begin
        code = '0;
        for (int j = 0; j < NUM_NEIGHBOURS; j++) begin
            code[j] = i_s_axis_tdata[PIX_BITS*(j+1) +: PIX_BITS]
                      >= i_s_axis_tdata[PIX_BITS-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_ACCUM: begin
                if (r_s1_valid && r_s1_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (rd_issue && r_rd_row == LAST_ROW) begin
                    n_state = ST_ACCUM;
                end
            end
            default: n_state = ST_ACCUM;
        endcase
    end

    always_comb begin
        o_s_axis_tready = 1'b0;
        rd_issue        = 1'b0;
        rd_addr         = code[CODE_BITS-1:SEL_BITS];
        unique case (r_state)
            ST_ACCUM: begin
                o_s_axis_tready = !(r_s1_valid && r_s1_last);
            end
            ST_DRAIN: begin
                rd_issue = !r_rd_pend && (!r_out_valid || i_m_axis_tready);
                rd_addr  = r_rd_row;
            end
            default: begin
                o_s_axis_tready = 1'b0;
            end
        endcase
    end

    assign in_take = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        if (!r_row_vld[r_s1_row]) begin
            old_row = '0;
        end else if (r_wb_valid && r_wb_row == r_s1_row) begin
            old_row = r_wb_data;
        end else begin
            old_row = r_mem_rdata;
        end
        new_row = old_row;
        if (old_row[r_s1_sel] != COUNT_MAX) begin
            new_row[r_s1_sel] = old_row[r_s1_sel] + COUNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_mem[r_s1_row] <= new_row;
        end
        r_mem_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_ACCUM;
            r_row_vld   <= '0;
            r_s1_valid  <= 1'b0;
            r_wb_valid  <= 1'b0;
            r_rd_row    <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_s1_valid <= in_take;
            r_wb_valid <= r_s1_valid;
            r_rd_pend  <= rd_issue;
            if (r_s1_valid) begin
                r_row_vld[r_s1_row] <= 1'b1;
            end
            if (rd_issue) begin
                r_row_vld[r_rd_row] <= 1'b0;
                r_rd_row            <= r_rd_row + ROW_BITS'(1);
            end
            if (r_rd_pend) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_last <= i_s_axis_tlast;
        r_s1_row  <= code[CODE_BITS-1:SEL_BITS];
        r_s1_sel  <= code[SEL_BITS-1:0];
        r_wb_row  <= r_s1_row;
        r_wb_data <= new_row;
        if (rd_issue) begin
            r_rd_vld  <= r_row_vld[r_rd_row];
            r_rd_base <= r_rd_row;
        end
        if (r_rd_pend) begin
            r_out_counts <= r_rd_vld ? r_mem_rdata : '0;
            r_out_row    <= r_rd_base;
            r_out_last   <= (r_rd_base == LAST_ROW);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = OUT_DATA_BITS'({
        FIELD_BITS'(r_out_counts[3]),
        FIELD_BITS'(r_out_counts[2]),
        FIELD_BITS'(r_out_counts[1]),
        FIELD_BITS'(r_out_counts[0]),
        r_out_row, {SEL_BITS{1'b0}}
    });

endmodule

// ----- tb/lbp_region_histogram_tb.sv -----
// ----------------------------------------------------------------------------
// lbp_region_histogram_tb
// Self-checking bench for the LBP region histogram.
// ----------------------------------------------------------------------------
// Pixel beats go in from a queue with random gaps, and the result stream is
// stalled at random. The bench counts every accepted pixel into its own
// saturating histogram, and on a region end it queues the 64 rows that the
// block must return. Each result beat is checked field by field against the
// oldest queued row. The stimulus has a directed set of code patterns, a run
// of pixels that all fall into a single bin, and a random part.
// ----------------------------------------------------------------------------
module lbp_region_histogram_tb
    import lrh_pkg::*;
();

    localparam int CLK_PERIOD = 20;
    localparam int RANDOM_PIXELS = 200;
    localparam int FILL_RUN = 30;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic                                    last;
        logic [NUM_NEIGHBOURS-1:0][PIX_BITS-1:0] nb;
        logic [PIX_BITS-1:0]                     centre;
    } t_pixel_beat;

    typedef struct packed {
        logic                      run_last;
        logic [3:0][FIELD_BITS-1:0] counts;
        logic [CODE_BITS-1:0]      first_bin;
    } t_hist_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_s_axis_tvalid = 1'b0;
    logic                     o_s_axis_tready;
    logic [IN_DATA_BITS-1:0]  i_s_axis_tdata = '0;
    logic                     i_s_axis_tlast = 1'b0;
    logic                     o_m_axis_tvalid;
    logic                     i_m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] o_m_axis_tdata;
    logic                     o_m_axis_tlast;

    lbp_region_histogram dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    t_pixel_beat           pending_pixels[$];
    t_hist_row             hist_rows_due[$];
    logic [COUNT_BITS-1:0] hist_bins[NUM_BINS];

    bit in_fire = 1'b0;
    bit steady = 1'b0;
    int src_wait = 0;
    int snk_wait = 0;
    int mismatches = 0;
    int pixels_taken = 0;
    int readouts = 0;
    int rows_checked = 0;
    int full_bins_seen = 0;

    initial begin
        for (int b = 0; b < NUM_BINS; b++) begin
            hist_bins[b] = '0;
        end
    end

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic add_pixel(input t_pixel_beat p);
        pending_pixels.insert(pending_pixels.size(), p);
    endtask

    function automatic logic [CODE_BITS-1:0] pattern_of(input t_pixel_beat p);
        logic [CODE_BITS-1:0] code;
        code = '0;
        for (int j = 0; j < NUM_NEIGHBOURS; j++) begin
            if (p.nb[j] >= p.centre) begin
                code[j] = 1'b1;
            end
        end
        return code;
    endfunction

    task automatic count_pixel(input t_pixel_beat p);
        logic [CODE_BITS-1:0] code;
        t_hist_row row;
        code = pattern_of(p);
        if (hist_bins[code] != COUNT_MAX) begin
            hist_bins[code] = hist_bins[code] + COUNT_BITS'(1);
        end
        pixels_taken++;
        if (p.last) begin
            readouts++;
            for (int base = 0; base < NUM_BINS; base += BINS_PER_RESULT) begin
                row.first_bin = CODE_BITS'(base);
                for (int k = 0; k < 4; k++) begin
                    if (k < BINS_PER_RESULT && base + k < NUM_BINS) begin
                        row.counts[k] = FIELD_BITS'(hist_bins[base + k]);
                    end else begin
                        row.counts[k] = '0;
                    end
                end
                row.run_last = (base + BINS_PER_RESULT >= NUM_BINS);
                hist_rows_due.insert(hist_rows_due.size(), row);
            end
            for (int b = 0; b < NUM_BINS; b++) begin
                hist_bins[b] = '0;
            end
        end
    endtask

    task automatic check_hist_row();
        t_hist_row want;
        logic [FIELD_BITS-1:0] got;
        if (hist_rows_due.size() == 0) begin
            report_error($sformatf("result beat with no row expected, tdata %h",
                                   o_m_axis_tdata));
        end else begin
            want = hist_rows_due.pop_front();
            if (o_m_axis_tdata[CODE_BITS-1:0] != want.first_bin) begin
                report_error($sformatf("first_bin got %0d expected %0d",
                                       o_m_axis_tdata[CODE_BITS-1:0], want.first_bin));
            end
            for (int k = 0; k < 4; k++) begin
                got = o_m_axis_tdata[CODE_BITS + k * FIELD_BITS +: FIELD_BITS];
                if (got != want.counts[k]) begin
                    report_error($sformatf("bin %0d count got %0d expected %0d",
                                           want.first_bin + k, got, want.counts[k]));
                end
                if (want.counts[k] == FIELD_BITS'(COUNT_MAX)) begin
                    full_bins_seen++;
                end
            end
            if (o_m_axis_tlast != want.run_last) begin
                report_error($sformatf("run_last got %0b expected %0b at bin %0d",
                                       o_m_axis_tlast, want.run_last, want.first_bin));
            end
            rows_checked++;
        end
    endtask

    // Mostly short gaps, a few long ones, none at all during a steady stretch.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    always @(posedge i_clk) begin : monitor
        in_fire <= i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                check_hist_row();
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                count_pixel(t_pixel_beat'({i_s_axis_tlast, i_s_axis_tdata}));
            end
        end
    end

    always @(negedge i_clk) begin : pixel_driver
        t_pixel_beat nxt;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || in_fire) begin
            if (src_wait > 0) begin
                src_wait--;
                i_s_axis_tvalid <= 1'b0;
            end else if (pending_pixels.size() != 0) begin
                nxt = pending_pixels.pop_front();
                i_s_axis_tdata <= {nxt.nb, nxt.centre};
                i_s_axis_tlast <= nxt.last;
                i_s_axis_tvalid <= 1'b1;
                src_wait = pick_gap();
                if ($urandom_range(0, 63) == 0) begin
                    steady = !steady;
                end
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : result_sink
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (snk_wait > 0) begin
            snk_wait--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
                snk_wait = pick_gap();
            end
        end
    end

    function automatic t_pixel_beat make_pixel(input logic [PIX_BITS-1:0] centre,
                                               input logic [PIX_BITS-1:0] others,
                                               input int sel, input logic [PIX_BITS-1:0] sel_val,
                                               input logic last);
        t_pixel_beat p;
        p.centre = centre;
        p.last = last;
        for (int j = 0; j < NUM_NEIGHBOURS; j++) begin
            p.nb[j] = (j == sel) ? sel_val : others;
        end
        return p;
    endfunction

    initial begin : stimulus
        t_pixel_beat p;
        int c;
        int d;
        int style;

        // Directed: equal values, the extremes and each code bit on its own.
        add_pixel(make_pixel(8'd0, 8'd0, -1, 8'd0, 1'b0));
        add_pixel(make_pixel(8'd255, 8'd254, -1, 8'd0, 1'b0));
        add_pixel(make_pixel(8'd255, 8'd255, -1, 8'd0, 1'b0));
        add_pixel(make_pixel(8'd255, 8'd0, 7, 8'd255, 1'b0));
        add_pixel(make_pixel(8'd0, 8'd255, 0, 8'd0, 1'b0));
        for (int j = 0; j < NUM_NEIGHBOURS; j++) begin
            add_pixel(make_pixel(8'd128, 8'd127, j, 8'd128, 1'b0));
        end
        p = make_pixel(8'd128, 8'd127, -1, 8'd0, 1'b0);
        for (int j = 0; j < NUM_NEIGHBOURS; j += 2) begin
            p.nb[j] = 8'd129;
        end
        add_pixel(p);
        add_pixel(make_pixel(8'd1, 8'd0, 3, 8'd1, 1'b0));
        add_pixel(make_pixel(8'd0, 8'd255, -1, 8'd0, 1'b1));
        add_pixel(make_pixel(8'd200, 8'd10, -1, 8'd0, 1'b1));

        // One bin hit by every pixel of a single region.
        for (int i = 0; i < FILL_RUN; i++) begin
            c = $urandom_range(0, 255);
            p.centre = PIX_BITS'(c);
            for (int j = 0; j < NUM_NEIGHBOURS; j++) begin
                p.nb[j] = PIX_BITS'($urandom_range(c, 255));
            end
            p.last = (i == FILL_RUN - 1);
            add_pixel(p);
        end

        for (int i = 0; i < RANDOM_PIXELS; i++) begin
            c = $urandom_range(0, 255);
            style = $urandom_range(0, 9);
            p.centre = PIX_BITS'(c);
            for (int j = 0; j < NUM_NEIGHBOURS; j++) begin
                if (style < 6) begin
                    d = c + int'($urandom_range(0, 6)) - 3;
                    p.nb[j] = (d < 0) ? 8'd0 : (d > 255) ? 8'd255 : PIX_BITS'(d);
                end else if (style < 9) begin
                    p.nb[j] = PIX_BITS'($urandom_range(0, 255));
                end else begin
                    p.nb[j] = PIX_BITS'(c);
                end
            end
            p.last = (i == RANDOM_PIXELS - 1) || ($urandom_range(0, 15) == 0);
            add_pixel(p);
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_pixels.size() != 0 || i_s_axis_tvalid || hist_rows_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Counted %0d pixel beats over %0d region readouts.", pixels_taken, readouts);
        $display("Checked %0d result beats, %0d of them with a full bin; %0d errors.",
                 rows_checked, full_bins_seen, mismatches);
        if (mismatches == 0) begin
            $display("** lbp_region_histogram: PASSED **");
        end else begin
            $display("** lbp_region_histogram: FAILED **");
        end
        $finish;
    end

    initial begin : watchdog
        #(CLK_PERIOD * 1_000_000);
        $display("Timeout with %0d pixel beats and %0d rows still outstanding.",
                 pending_pixels.size(), hist_rows_due.size());
        $display("** lbp_region_histogram: FAILED **");
        $finish;
    end

endmodule
